>>> rtl/vdc_pkg.sv
package vdc_pkg;

	typedef enum logic [3:0] {
		ACT_RESET      = 4'd0,
		ACT_CONO_CLR   = 4'd1,
		ACT_CONO_SET   = 4'd2,
		ACT_DATAO_CLR  = 4'd3,
		ACT_DATAO_SET  = 4'd4,
		ACT_STATUS     = 4'd5,
		ACT_DATAI      = 4'd6,
		ACT_TICK       = 4'd7,
		ACT_PEN        = 4'd8
	} action_t;

	typedef enum logic [3:0] {
		SQ_IDLE  = 4'd0,
		SQ_SYNC  = 4'd1,
		SQ_LOAD  = 4'd2,
		SQ_DLY   = 4'd3,
		SQ_EXEC  = 4'd4,
		SQ_XYINT = 4'd5,
		SQ_SEQ   = 4'd6,
		SQ_READY = 4'd9
	} seq_t;

	localparam logic [2:0] M_PT    = 3'd0;
	localparam logic [2:0] M_XY    = 3'd1;
	localparam logic [2:0] M_CH    = 3'd3;
	localparam logic [2:0] M_VEC   = 3'd4;
	localparam logic [2:0] M_VCONT = 3'd5;
	localparam logic [2:0] M_INC   = 3'd6;

	typedef struct packed {
		logic stop;
		logic halt;
		logic move;
		logic find;
		logic lpf;
		logic lpen;
		logic rdy;
		logic hef;
		logic vef;
	} flags_t;

	typedef struct packed {
		logic [35:0] input_buffer;
		logic [1:0]  halves;
		logic [17:0] work_word;
		logic [19:0] shifted_points;
		logic [2:0]  draw_mode;
		logic [2:0]  brightness;
		logic [1:0]  step_scale;
		logic [6:0]  rate_counter;
		logic [6:0]  rate_add;
		logic [6:0]  rate_complement;
		logic [3:0]  sub_shift;
		logic [9:0]  beam_x;
		logic [9:0]  beam_y;
		flags_t      flags;
		seq_t        seq;
		logic [2:0]  level_data;
		logic [2:0]  level_special;
		logic [20:0] pen;
	} state_t;

	typedef struct packed {
		logic [35:0] read_data;
		logic        point_valid;
		logic [9:0]  point_x;
		logic [9:0]  point_y;
		logic [2:0]  point_level;
		logic [7:0]  data_request;
		logic [7:0]  special_request;
	} result_t;

endpackage

>>> rtl/vdc_core.sv
module vdc_core (
	input  vdc_pkg::state_t  cur,
	input  logic [3:0]       action,
	input  logic [35:0]      bus_data,
	input  logic [9:0]       pen_x,
	input  logic [9:0]       pen_y,
	input  logic             pen_down,
	output vdc_pkg::state_t  nxt,
	output vdc_pkg::result_t res
);

	vdc_pkg::state_t s;
	logic        pt_on;
	logic [9:0]  pt_x;
	logic [9:0]  pt_y;
	logic [2:0]  pt_l;
	logic        held;
	logic        r, l, u, d;
	logic        go_h, go_v;
	logic [6:0]  prev_cnt;
	logic [6:0]  chg;
	logic [6:0]  hit;
	logic [6:0]  big;
	logic [3:0]  nib;
	logic [10:0] amt;
	logic signed [11:0] v;
	logic        do_move;
	logic        dreq;
	logic        sreq;

	// pen hit test: is the pen within a squared distance of 4 of the current beam
	function automatic logic pen_hit(input logic [20:0] pen, input logic [9:0] bx,
			input logic [9:0] by);
		logic signed [10:0] ddx;
		logic signed [10:0] ddy;
		logic signed [21:0] ex;
		logic signed [21:0] ey;
		logic [21:0] sq;
		ddx = $signed({1'b0, pen[9:0]}) - $signed({1'b0, bx});
		ddy = $signed({1'b0, pen[19:10]}) - $signed({1'b0, by});
		ex = ddx;
		ey = ddy;
		sq = ex * ex + ey * ey;
		pen_hit = (sq <= 22'd4);
	endfunction

	always_comb begin
		s = cur;
		pt_on = 1'b0;
		pt_x = '0;
		pt_y = '0;
		pt_l = '0;
		held = 1'b0;
		r = 1'b0; l = 1'b0; u = 1'b0; d = 1'b0;
		go_h = 1'b0; go_v = 1'b0;
		prev_cnt = '0;
		chg = '0;
		hit = '0;
		big = '0;
		nib = '0;
		amt = '0;
		v = '0;
		do_move = 1'b0;
		res = '0;
		case (action)
			vdc_pkg::ACT_RESET: begin
				s.level_data = '0;
				s.level_special = '0;
				s.input_buffer = '0;
				s.halves = '0;
				s.flags.lpen = 1'b0; s.flags.find = 1'b0;
				s.flags.lpf = 1'b0; s.flags.stop = 1'b0;
				s.draw_mode = '0;
				s.seq = vdc_pkg::SQ_READY;
			end
			vdc_pkg::ACT_CONO_CLR: begin
				s.level_data = '0;
				s.level_special = '0;
			end
			vdc_pkg::ACT_CONO_SET: begin
				s.level_data = s.level_data | bus_data[2:0];
				s.level_special = s.level_special | bus_data[5:3];
				if (bus_data[6]) begin
					s.flags.lpen = 1'b0; s.flags.find = 1'b0;
					s.flags.lpf = 1'b0; s.flags.stop = 1'b0;
					s.draw_mode = '0;
					s.seq = vdc_pkg::SQ_READY;
				end else begin
					s.flags.lpen = 1'b0; s.flags.find = 1'b0; s.flags.lpf = 1'b0;
					if (s.draw_mode != vdc_pkg::M_CH) s.seq = vdc_pkg::SQ_SEQ;
				end
			end
			vdc_pkg::ACT_DATAO_CLR: begin
				s.input_buffer = '0;
				s.halves = '0;
			end
			vdc_pkg::ACT_DATAO_SET: begin
				s.input_buffer = s.input_buffer | bus_data;
				s.halves = 2'd2;
			end
			vdc_pkg::ACT_STATUS: begin
				res.read_data = 36'({s.draw_mode, 15'd0});
				res.read_data[11] = s.flags.vef;
				res.read_data[10] = s.flags.lpf;
				res.read_data[9] = s.flags.hef;
				res.read_data[8] = s.flags.stop & s.work_word[9];
				res.read_data[7] = (s.halves == 2'd0) & s.flags.rdy;
				res.read_data[5:3] = s.level_special;
				res.read_data[2:0] = s.level_data;
			end
			vdc_pkg::ACT_DATAI: begin
				res.read_data = {8'd0, s.beam_y, 8'd0, s.beam_x};
			end
			vdc_pkg::ACT_PEN: begin
				s.pen = {pen_down, pen_y, pen_x};
			end
			vdc_pkg::ACT_TICK: begin
				case (s.seq)
					vdc_pkg::SQ_IDLE: begin
						if (s.flags.rdy && s.halves != 2'd0) s.seq = vdc_pkg::SQ_SYNC;
					end
					vdc_pkg::SQ_SYNC: begin
						s.work_word = '0;
						s.rate_counter = '0;
						s.sub_shift = '0;
						s.flags.rdy = 1'b0; s.flags.halt = 1'b0; s.flags.move = 1'b0;
						s.flags.hef = 1'b0; s.flags.vef = 1'b0;
						s.seq = vdc_pkg::SQ_LOAD;
					end
					vdc_pkg::SQ_LOAD: begin
						if (s.flags.find && s.flags.lpen) s.flags.lpf = 1'b1;
						if (s.draw_mode == vdc_pkg::M_INC) s.sub_shift[3] = 1'b1;
						if (s.draw_mode == vdc_pkg::M_CH) s.sub_shift[2] = 1'b1;
						s.work_word = s.work_word | s.input_buffer[35:18];
						s.shifted_points = {2'd0, s.work_word};
						big = (s.work_word[14:8] > s.work_word[6:0]) ? s.work_word[14:8]
							: s.work_word[6:0];
						s.rate_add = big[6] ? 7'd1 : 7'd2;
						s.rate_complement = s.rate_add - 7'd1;
						s.input_buffer = {s.input_buffer[17:0], 18'd0};
						if (s.halves != 2'd0) s.halves = s.halves - 2'd1;
						s.seq = vdc_pkg::SQ_DLY;
					end
					vdc_pkg::SQ_DLY: begin
						if (s.flags.move && s.work_word[17]) begin
							if (s.pen[20] && s.flags.lpen && pen_hit(s.pen, s.beam_x, s.beam_y))
								s.flags.find = 1'b1;
							pt_on = 1'b1; pt_x = s.beam_x; pt_y = s.beam_y; pt_l = s.brightness;
						end
						s.seq = vdc_pkg::SQ_EXEC;
					end
					vdc_pkg::SQ_EXEC: begin
						s.seq = vdc_pkg::SQ_IDLE;
						case (s.draw_mode)
							vdc_pkg::M_PT: begin
								s.draw_mode = s.work_word[15:13];
								if (s.work_word[12]) s.flags.lpen = s.work_word[11];
								if (s.work_word[3]) s.brightness = s.work_word[2:0];
								if (s.work_word[6]) s.step_scale = s.work_word[5:4];
								if (s.work_word[10]) s.flags.stop = 1'b1;
								else s.seq = vdc_pkg::SQ_READY;
							end
							vdc_pkg::M_XY: begin
								if (!s.flags.lpf) begin
									s.draw_mode = s.work_word[15:13];
									if (s.work_word[12]) s.flags.lpen = s.work_word[11];
									if (s.work_word[17]) s.beam_y = s.work_word[9:0];
									else s.beam_x = s.work_word[9:0];
									s.seq = vdc_pkg::SQ_XYINT;
								end
							end
							vdc_pkg::M_CH: s.seq = vdc_pkg::SQ_READY;
							vdc_pkg::M_INC, vdc_pkg::M_VEC, vdc_pkg::M_VCONT: begin
								do_move = 1'b1;
								held = s.flags.halt;
								prev_cnt = s.rate_counter;
								s.rate_counter = (s.rate_counter + s.rate_add) ^ s.rate_complement;
								s.sub_shift = {1'b0, s.sub_shift[3:1]};
								s.shifted_points = {s.shifted_points[15:0], 4'd0};
								if (s.draw_mode == vdc_pkg::M_INC) begin
									nib = s.shifted_points[19:16];
									r = nib[3:2] == 2'b10;
									l = nib[3:2] == 2'b11;
									u = nib[1:0] == 2'b10;
									d = nib[1:0] == 2'b11;
								end else begin
									chg = s.rate_counter ^ prev_cnt;
									hit = ~prev_cnt & chg;
									for (int k = 0; k < 7; k++) begin
										if (hit[k] && s.work_word[6 - k]) go_h = 1'b1;
										if (hit[k] && s.work_word[14 - k]) go_v = 1'b1;
									end
									r = go_h & ~s.work_word[7];
									l = go_h & s.work_word[7];
									u = go_v & ~s.work_word[15];
									d = go_v & s.work_word[15];
								end
							end
							default: ;
						endcase
						if (do_move) begin
							amt = 11'd1 << s.step_scale;
							v = $signed({2'd0, s.beam_y});
							if (u) v = v + $signed({1'b0, amt});
							if (d) v = v - $signed({1'b0, amt});
							if (u || d) s.flags.move = 1'b1;
							if (v < 0 || v > 12'sd1023) s.flags.vef = 1'b1;
							s.beam_y = v[9:0];
							if (s.flags.find && s.flags.lpen) s.flags.lpf = 1'b1;
							v = $signed({2'd0, s.beam_x});
							if (r) v = v + $signed({1'b0, amt});
							if (l) v = v - $signed({1'b0, amt});
							if (r || l) s.flags.move = 1'b1;
							if (v < 0 || v > 12'sd1023) s.flags.hef = 1'b1;
							s.beam_x = v[9:0];
							if (s.draw_mode == vdc_pkg::M_INC && s.sub_shift[0]) s.flags.halt = 1'b1;
							if (held) begin
								if (s.work_word[17]) begin
									s.draw_mode = '0;
									s.flags.find = 1'b0;
								end
								s.seq = vdc_pkg::SQ_READY;
							end else begin
								s.seq = vdc_pkg::SQ_SEQ;
							end
						end
					end
					vdc_pkg::SQ_SEQ: begin
						s.seq = vdc_pkg::SQ_IDLE;
						if (s.draw_mode == vdc_pkg::M_VEC && s.rate_counter == 7'h7f)
							s.flags.halt = 1'b1;
						if (s.flags.hef || s.flags.vef) begin
							// mode is cleared and the sequencer goes idle, so continue mode never reaches ready
							s.draw_mode = '0;
							s.flags.find = 1'b0;
						end else if (!s.flags.rdy && !s.flags.lpf) begin
							s.seq = vdc_pkg::SQ_DLY;
						end
					end
					vdc_pkg::SQ_XYINT: begin
						if (s.work_word[10]) begin
							if (s.pen[20] && s.flags.lpen && pen_hit(s.pen, s.beam_x, s.beam_y))
								s.flags.find = 1'b1;
							pt_on = 1'b1; pt_x = s.beam_x; pt_y = s.beam_y; pt_l = s.brightness;
						end
						s.seq = vdc_pkg::SQ_READY;
					end
					vdc_pkg::SQ_READY: begin
						s.flags.rdy = 1'b1;
						s.flags.hef = 1'b0;
						s.flags.vef = 1'b0;
						s.seq = vdc_pkg::SQ_IDLE;
					end
					default: s.seq = vdc_pkg::SQ_IDLE;
				endcase
			end
			default: ;
		endcase
		dreq = (s.halves == 2'd0) && s.flags.rdy;
		sreq = s.flags.lpf || s.flags.hef || s.flags.vef || (s.flags.stop && s.work_word[9]);
		res.point_valid = pt_on;
		res.point_x = pt_x;
		res.point_y = pt_y;
		res.point_level = pt_l;
		res.data_request = dreq ? (8'h80 >> s.level_data) : 8'd0;
		res.special_request = sreq ? (8'h80 >> s.level_special) : 8'd0;
		nxt = s;
	end

endmodule

>>> rtl/vector_display_controller_top.sv
// Vector display controller. One word per cycle in, one result word per cycle
// out unless m_tready stalls it: each input word (bus access, pen update or
// sequencer tick) is registered, processed by one pass of combinational logic
// that updates the controller state, and its result lands in an output
// register. A new word is taken every cycle while the output register is empty
// or being drained. Character mode is not drawn: such a word is consumed and
// the block returns to ready-for-data.
module vector_display_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[3:0], bus_data[39:4], pen_x[49:40], pen_y[59:50], pen_down[60]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[35:0], point_valid[36], point_x[46:37], point_y[56:47],
	// point_level[59:57], data_request[67:60], special_request[75:68]
	output logic [79:0] m_tdata
);

	vdc_pkg::state_t  st_q;
	vdc_pkg::state_t  st_nxt;
	vdc_pkg::result_t res;
	logic [60:0]      in_s1;
	logic             vld_s1;
	logic             adv;

	// output register frees up whenever it is drained
	assign adv = vld_s1 && (!m_tvalid || m_tready);
	assign s_tready = !vld_s1 || adv;

	vdc_core u_core (
		.cur      (st_q),
		.action   (in_s1[3:0]),
		.bus_data (in_s1[39:4]),
		.pen_x    (in_s1[49:40]),
		.pen_y    (in_s1[59:50]),
		.pen_down (in_s1[60]),
		.nxt      (st_nxt),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			m_tvalid <= 1'b0;
			st_q <= '{seq: vdc_pkg::SQ_READY, default: '0};
		end else begin
			if (s_tready) vld_s1 <= s_tvalid;
			if (adv) begin
				st_q <= st_nxt;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) in_s1 <= s_tdata[60:0];
		if (adv) m_tdata <= {4'd0, res.special_request, res.data_request, res.point_level,
			res.point_y, res.point_x, res.point_valid, res.read_data};
	end

endmodule

>>> test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT_NS = 5_000_000;
	localparam int LONG_HOLD = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;

	vector_display_controller_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// display controller image kept by the predictor
	logic [35:0] ibuf;
	int          halves;
	logic [17:0] ww;
	logic [19:0] spts;
	logic [2:0]  mode, bright, lv_data, lv_spec;
	logic [1:0]  scale;
	logic [6:0]  rcnt, radd, rcomp;
	logic [3:0]  ssh;
	logic [9:0]  bx, by;
	vdc_pkg::flags_t fl;
	vdc_pkg::seq_t   seq;
	logic [20:0] pen;
	logic        pt_on;
	logic [9:0]  pt_x, pt_y;
	logic [2:0]  pt_l;

	logic [63:0]        words_pending[$];
	vdc_pkg::result_t   results_due[$];
	int          send_idle_pct = 0, recv_idle_pct = 0;
	logic        taken = 1'b0;
	logic        hold_go = 1'b0;
	int          hold_left = 0;
	int          mismatches = 0, checked = 0, points_seen = 0;
	logic        failed = 1'b0;

	function automatic void controller_reset();
		ibuf = '0; halves = 0; ww = '0; spts = '0; mode = vdc_pkg::M_PT; bright = '0;
		scale = '0; rcnt = '0; radd = '0; rcomp = '0; ssh = '0; bx = '0; by = '0;
		fl = '0; lv_data = '0; lv_spec = '0; pen = '0; seq = vdc_pkg::SQ_READY;
	endfunction

	function automatic void light_point();
		int dx, dy;
		if (pen[20] && fl.lpen) begin
			dx = int'(pen[9:0]) - int'(bx);
			dy = int'(pen[19:10]) - int'(by);
			if (dx * dx + dy * dy <= 4) fl.find = 1'b1;
		end
		pt_on = 1'b1; pt_x = bx; pt_y = by; pt_l = bright;
	endfunction

	function automatic void leave_mode();
		mode = vdc_pkg::M_PT;
		fl.find = 1'b0;
	endfunction

	function automatic void start_over();
		fl.lpen = 1'b0; fl.find = 1'b0; fl.lpf = 1'b0; fl.stop = 1'b0;
		leave_mode();
		seq = vdc_pkg::SQ_READY;
	endfunction

	function automatic void take_mode();
		mode = ww[15:13];
		if (ww[12]) fl.lpen = ww[11];
	endfunction

	function automatic void step_rate();
		rcnt = (rcnt + radd) ^ rcomp;
		ssh = ssh >> 1;
		spts = spts << 4;
	endfunction

	function automatic void pick_dir(input logic [6:0] oldc, input logic [7:0] delta,
			input logic [6:0] changed, output logic plus, output logic minus);
		logic [6:0] hit;
		logic go;
		hit = ~oldc & changed;
		go = 1'b0;
		for (int k = 0; k < 7; k++)
			if (hit[k] && delta[6 - k]) go = 1'b1;
		plus = go && !delta[7];
		minus = go && delta[7];
	endfunction

	function automatic logic [9:0] move_axis(input logic [9:0] pos, input int amt,
			input logic plus, input logic minus, input logic vertical);
		int v;
		v = int'(pos);
		if (plus) v += amt;
		if (minus) v -= amt;
		if (plus || minus) fl.move = (mode != vdc_pkg::M_CH);
		if (v < 0 || v >= 1024) begin
			if (vertical) fl.vef = 1'b1;
			else fl.hef = 1'b1;
		end
		return v[9:0];
	endfunction

	function automatic void exec_word();
		logic r, l, u, d, held;
		logic [6:0] prev;
		logic [3:0] nib;
		int amt;
		r = 0; l = 0; u = 0; d = 0; held = 0;
		seq = vdc_pkg::SQ_IDLE;
		case (mode)
			vdc_pkg::M_PT: begin
				take_mode();
				if (ww[3]) bright = ww[2:0];
				if (ww[6]) scale = ww[5:4];
				if (ww[10]) fl.stop = 1'b1;
				else seq = vdc_pkg::SQ_READY;
				return;
			end
			vdc_pkg::M_XY: begin
				if (fl.lpf) return;
				take_mode();
				if (ww[17]) by = ww[9:0];
				else bx = ww[9:0];
				seq = vdc_pkg::SQ_XYINT;
				return;
			end
			vdc_pkg::M_CH: begin
				seq = vdc_pkg::SQ_READY;
				return;
			end
			vdc_pkg::M_INC: begin
				held = fl.halt;
				step_rate();
				nib = spts[19:16];
				r = nib[3:2] == 2'b10;
				l = nib[3:2] == 2'b11;
				u = nib[1:0] == 2'b10;
				d = nib[1:0] == 2'b11;
			end
			vdc_pkg::M_VEC, vdc_pkg::M_VCONT: begin
				prev = rcnt;
				held = fl.halt;
				step_rate();
				pick_dir(prev, ww[7:0], rcnt ^ prev, r, l);
				pick_dir(prev, ww[15:8], rcnt ^ prev, u, d);
			end
			default: return;
		endcase
		amt = 1 << scale;
		by = move_axis(by, amt, u, d, 1'b1);
		if (fl.find && fl.lpen) fl.lpf = 1'b1;
		bx = move_axis(bx, amt, r, l, 1'b0);
		if (mode == vdc_pkg::M_INC && ssh[0]) fl.halt = 1'b1;
		if (held) begin
			if (ww[17]) leave_mode();
			seq = vdc_pkg::SQ_READY;
		end else begin
			seq = vdc_pkg::SQ_SEQ;
		end
	endfunction

	function automatic void advance_sequencer();
		logic [6:0] big;
		case (seq)
			vdc_pkg::SQ_IDLE: if (fl.rdy && halves > 0) seq = vdc_pkg::SQ_SYNC;
			vdc_pkg::SQ_SYNC: begin
				ww = '0; rcnt = '0; ssh = '0;
				fl.rdy = 0; fl.halt = 0; fl.move = 0; fl.hef = 0; fl.vef = 0;
				seq = vdc_pkg::SQ_LOAD;
			end
			vdc_pkg::SQ_LOAD: begin
				if (fl.find && fl.lpen) fl.lpf = 1'b1;
				if (mode == vdc_pkg::M_INC) ssh[3] = 1'b1;
				if (mode == vdc_pkg::M_CH) ssh[2] = 1'b1;
				ww = ww | ibuf[35:18];
				spts = {2'b00, ww};
				big = ww[6:0];
				if (ww[14:8] > big) big = ww[14:8];
				radd = big[6] ? 7'd1 : 7'd2;
				rcomp = radd - 7'd1;
				ibuf = {ibuf[17:0], 18'd0};
				if (halves > 0) halves--;
				seq = vdc_pkg::SQ_DLY;
			end
			vdc_pkg::SQ_DLY: begin
				if (fl.move && ww[17]) light_point();
				seq = vdc_pkg::SQ_EXEC;
			end
			vdc_pkg::SQ_EXEC: exec_word();
			vdc_pkg::SQ_SEQ: begin
				seq = vdc_pkg::SQ_IDLE;
				if (mode == vdc_pkg::M_VEC && rcnt == 7'h7f) fl.halt = 1'b1;
				if (fl.hef || fl.vef) begin
					leave_mode();
					if (mode == vdc_pkg::M_VCONT) seq = vdc_pkg::SQ_READY;
				end else if (!fl.rdy && !fl.lpf) begin
					seq = vdc_pkg::SQ_DLY;
				end
			end
			vdc_pkg::SQ_XYINT: begin
				if (ww[10]) light_point();
				seq = vdc_pkg::SQ_READY;
			end
			vdc_pkg::SQ_READY: begin
				fl.rdy = 1'b1; fl.hef = 1'b0; fl.vef = 1'b0;
				seq = vdc_pkg::SQ_IDLE;
			end
			default: seq = vdc_pkg::SQ_IDLE;
		endcase
	endfunction

	function automatic vdc_pkg::result_t predict_result(input logic [63:0] w);
		vdc_pkg::result_t res;
		logic [35:0] bus, rd;
		logic [3:0] act;
		logic sreq;
		act = w[3:0];
		bus = w[39:4];
		rd = '0;
		pt_on = 0; pt_x = '0; pt_y = '0; pt_l = '0;
		case (act)
			vdc_pkg::ACT_RESET: begin
				lv_data = '0; lv_spec = '0; ibuf = '0; halves = 0;
				start_over();
			end
			vdc_pkg::ACT_CONO_CLR: begin
				lv_data = '0; lv_spec = '0;
			end
			vdc_pkg::ACT_CONO_SET: begin
				lv_data |= bus[2:0];
				lv_spec |= bus[5:3];
				if (bus[6]) begin
					start_over();
				end else begin
					fl.lpen = 0; fl.find = 0; fl.lpf = 0;
					if (mode != vdc_pkg::M_CH) seq = vdc_pkg::SQ_SEQ;
				end
			end
			vdc_pkg::ACT_DATAO_CLR: begin
				ibuf = '0; halves = 0;
			end
			vdc_pkg::ACT_DATAO_SET: begin
				ibuf |= bus; halves = 2;
			end
			vdc_pkg::ACT_STATUS: begin
				rd = 36'(mode) << 15;
				rd[11] = fl.vef;
				rd[10] = fl.lpf;
				rd[9] = fl.hef;
				rd[8] = fl.stop && ww[9];
				rd[7] = halves == 0 && fl.rdy;
				rd[5:3] = lv_spec;
				rd[2:0] = lv_data;
			end
			vdc_pkg::ACT_DATAI: rd = {8'd0, by, 8'd0, bx};
			vdc_pkg::ACT_TICK: advance_sequencer();
			vdc_pkg::ACT_PEN: pen = {w[60], w[59:50], w[49:40]};
			default: ;
		endcase
		sreq = fl.lpf || fl.hef || fl.vef || (fl.stop && ww[9]);
		res.read_data = rd;
		res.point_valid = pt_on;
		res.point_x = pt_x;
		res.point_y = pt_y;
		res.point_level = pt_l;
		res.data_request = (halves == 0 && fl.rdy) ? (8'h80 >> lv_data) : 8'h00;
		res.special_request = sreq ? (8'h80 >> lv_spec) : 8'h00;
		return res;
	endfunction

	function automatic void queue_word(input logic [3:0] act, input logic [35:0] bus,
			input logic [9:0] px, input logic [9:0] py, input logic pd);
		words_pending.push_back({3'b000, pd, py, px, bus, act});
	endfunction

	function automatic logic [35:0] rand36();
		return {4'($urandom_range(15)), $urandom};
	endfunction

	// point-mode control half: mode, pen enable, stop, scale, intensity
	function automatic logic [17:0] control_half();
		logic [17:0] h;
		h = 18'(rand36());
		h[15:13] = 3'($urandom_range(7));
		h[10] = ($urandom_range(9) == 0);
		return h;
	endfunction

	function automatic void queue_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(15) == 0)
				queue_word($urandom_range(1) ? vdc_pkg::ACT_STATUS : vdc_pkg::ACT_DATAI,
					rand36(), 0, 0, 0);
			else
				queue_word(vdc_pkg::ACT_TICK, rand36(), 10'($urandom), 10'($urandom),
					1'($urandom));
		end
	endfunction

	function automatic void queue_frame();
		logic [35:0] cw;
		int words;
		if ($urandom_range(3) == 0) queue_word(vdc_pkg::ACT_RESET, rand36(), 0, 0, 0);
		if ($urandom_range(2) == 0) queue_word(vdc_pkg::ACT_CONO_CLR, rand36(), 0, 0, 0);
		cw = rand36();
		cw[6] = ($urandom_range(2) == 0);
		queue_word(vdc_pkg::ACT_CONO_SET, cw, 0, 0, 0);
		queue_word(vdc_pkg::ACT_PEN, rand36(), 10'($urandom_range(12)),
			10'($urandom_range(12)), 1'($urandom));
		words = $urandom_range(1, 4);
		for (int i = 0; i < words; i++) begin
			if (i == 0)
				queue_word(vdc_pkg::ACT_DATAO_SET, {control_half(), 18'(rand36())}, 0, 0, 0);
			else queue_word(vdc_pkg::ACT_DATAO_SET, rand36(), 0, 0, 0);
			queue_ticks($urandom_range(4, 40));
		end
		if ($urandom_range(4) == 0) queue_word(vdc_pkg::ACT_DATAO_CLR, rand36(), 0, 0, 0);
	endfunction

	function automatic void queue_noise();
		queue_word(4'($urandom_range(15)), rand36(), 10'($urandom), 10'($urandom),
			1'($urandom));
	endfunction

	function automatic void queue_random(input int n);
		int start;
		start = words_pending.size();
		while (words_pending.size() - start < n) begin
			if ($urandom_range(9) == 0) queue_noise();
			else queue_frame();
		end
	endfunction

	task automatic drain();
		while (words_pending.size() != 0 || s_tvalid || results_due.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !taken)) begin
			if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tdata <= words_pending.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver with a single long hold-off
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = LONG_HOLD;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		vdc_pkg::result_t exp_r, got;
		taken = s_tvalid && s_tready;
		if (s_tvalid && s_tready) results_due.push_back(predict_result(s_tdata));
		if (m_tvalid && m_tready) begin
			got.read_data = m_tdata[35:0];
			got.point_valid = m_tdata[36];
			got.point_x = m_tdata[46:37];
			got.point_y = m_tdata[56:47];
			got.point_level = m_tdata[59:57];
			got.data_request = m_tdata[67:60];
			got.special_request = m_tdata[75:68];
			if (results_due.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
			end else begin
				exp_r = results_due.pop_front();
				checked++;
				if (got.point_valid) points_seen++;
				if (got !== exp_r) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at result %0d:", checked);
						$display("  read_data exp %h got %h, point exp %b/%h/%h/%h got %b/%h/%h/%h",
							exp_r.read_data, got.read_data, exp_r.point_valid, exp_r.point_x,
							exp_r.point_y, exp_r.point_level, got.point_valid, got.point_x,
							got.point_y, got.point_level);
						$display("  data_req exp %h got %h, special_req exp %h got %h",
							exp_r.data_request, got.data_request,
							exp_r.special_request, got.special_request);
					end
				end
			end
		end
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("Verification failed");
		$finish;
	end

	initial begin
		controller_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, every action, unused codes and a stop word
		queue_word(vdc_pkg::ACT_STATUS, '0, 0, 0, 0);
		queue_word(vdc_pkg::ACT_TICK, '0, 0, 0, 0);
		queue_word(vdc_pkg::ACT_STATUS, '0, 0, 0, 0);
		queue_word(vdc_pkg::ACT_PEN, '1, 10'h3ff, 10'h3ff, 1'b1);
		queue_word(vdc_pkg::ACT_PEN, '0, 0, 0, 1'b1);
		queue_word(vdc_pkg::ACT_CONO_SET, 36'o77, 0, 0, 0);
		queue_word(vdc_pkg::ACT_CONO_SET, '1, 0, 0, 0);
		queue_word(vdc_pkg::ACT_DATAO_SET, '1, 0, 0, 0);
		queue_ticks(6);
		queue_word(vdc_pkg::ACT_DATAO_SET, {18'o072000, 18'o040000}, 0, 0, 0);
		queue_ticks(6);
		queue_word(vdc_pkg::ACT_STATUS, '0, 0, 0, 0);
		queue_word(vdc_pkg::ACT_DATAI, '0, 0, 0, 0);
		queue_word(vdc_pkg::ACT_CONO_CLR, '0, 0, 0, 0);
		queue_word(vdc_pkg::ACT_DATAO_CLR, '0, 0, 0, 0);
		queue_word(4'd9, '1, 10'h3ff, 10'h3ff, 1'b1);
		queue_word(4'd15, '1, 10'h3ff, 10'h3ff, 1'b1);
		queue_word(vdc_pkg::ACT_RESET, '1, 0, 0, 0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 51; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 51; end
				default: begin send_idle_pct = 15; recv_idle_pct = 15; end
			endcase
			queue_random(160);
			if (phase == 0) hold_go = 1'b1;
			// let the sender stop until every result is back, then resume
			drain();
			queue_random(160);
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Checked %0d result words over four handshake phases, %0d with a lit point.",
			checked, points_seen);
		if (!failed && results_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end
endmodule
